>>> rtl/core/egcd_pkg.sv
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended gcd block: controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int unsigned OPND_W  = 32;
    localparam int unsigned COEFF_W = 33;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic out_load;
    } egcd_cmd_t;

    typedef struct packed {
        logic small_zero;
        logic div_last;
    } egcd_sts_t;

endpackage

>>> rtl/core/egcd_ctrl.sv
// ----------------------------------------------------------------------------
// egcd_ctrl
// Sequencer for the euclid loop: check, divide bit by bit, update, finish.
// ----------------------------------------------------------------------------
module egcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  egcd_pkg::egcd_sts_t  sts,
    output egcd_pkg::egcd_cmd_t  cmd
);

    egcd_pkg::state_t state_reg;
    egcd_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = egcd_pkg::ST_CHECK;
                end
            end
            egcd_pkg::ST_CHECK:
            begin
                state_next = sts.small_zero ? egcd_pkg::ST_FINISH : egcd_pkg::ST_DIV;
            end
            egcd_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = egcd_pkg::ST_UPDATE;
                end
            end
            egcd_pkg::ST_UPDATE:
            begin
                state_next = egcd_pkg::ST_CHECK;
            end
            egcd_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = egcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = egcd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            egcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            egcd_pkg::ST_CHECK:
            begin
                cmd.div_init = !sts.small_zero;
            end
            egcd_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            egcd_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            egcd_pkg::ST_FINISH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= egcd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/core/egcd_datapath.sv
// ----------------------------------------------------------------------------
// egcd_datapath
// Operand and coefficient registers, a restoring divider that yields one
// quotient bit per cycle, and two shift-add accumulators that form
// quotient times coefficient from the same bits, msb first.
// ----------------------------------------------------------------------------
module egcd_datapath #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  egcd_pkg::egcd_cmd_t                   cmd,
    output egcd_pkg::egcd_sts_t                   sts,
    input  logic [egcd_pkg::OPND_W-1:0]           operand_a,
    input  logic [egcd_pkg::OPND_W-1:0]           operand_b,
    output logic [egcd_pkg::OPND_W-1:0]           gcd_value,
    output logic signed [egcd_pkg::COEFF_W-1:0]   coeff_a,
    output logic signed [egcd_pkg::COEFF_W-1:0]   coeff_b
);

    localparam int unsigned CW = $clog2(WIDTH);
    localparam int unsigned CF = WIDTH + 1;

    logic [WIDTH-1:0] big_reg,    big_next;
    logic [WIDTH-1:0] small_reg,  small_next;
    logic [WIDTH-1:0] rem_reg,    rem_next;
    logic [WIDTH-1:0] dvd_reg,    dvd_next;
    logic [CF-1:0]    cob_reg,    cob_next;
    logic [CF-1:0]    cos_reg,    cos_next;
    logic [CF-1:0]    cnb_reg,    cnb_next;
    logic [CF-1:0]    cns_reg,    cns_next;
    logic [CF-1:0]    accb_reg,   accb_next;
    logic [CF-1:0]    accs_reg,   accs_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    logic             swap_reg,   swap_next;

    logic [egcd_pkg::OPND_W-1:0]  gcd_reg;
    logic [egcd_pkg::COEFF_W-1:0] ca_reg;
    logic [egcd_pkg::COEFF_W-1:0] cb_reg;

    logic [WIDTH-1:0] in_a;
    logic [WIDTH-1:0] in_b;
    logic             in_swap;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   trial;
    logic             qbit;

    assign in_a    = WIDTH'(operand_a);
    assign in_b    = WIDTH'(operand_b);
    assign in_swap = in_a < in_b;

    // one restoring division step
    assign shifted = {rem_reg, dvd_reg[WIDTH-1]};
    assign qbit    = shifted >= {1'b0, small_reg};
    assign trial   = shifted - {1'b0, small_reg};

    always_comb
    begin
        big_next   = big_reg;
        small_next = small_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        cob_next   = cob_reg;
        cos_next   = cos_reg;
        cnb_next   = cnb_reg;
        cns_next   = cns_reg;
        accb_next  = accb_reg;
        accs_next  = accs_reg;
        cnt_next   = cnt_reg;
        swap_next  = swap_reg;
        if (cmd.load)
        begin
            big_next   = in_swap ? in_b : in_a;
            small_next = in_swap ? in_a : in_b;
            swap_next  = in_swap;
            cob_next   = CF'(1);
            cos_next   = '0;
            cnb_next   = '0;
            cns_next   = CF'(1);
        end
        if (cmd.div_init)
        begin
            rem_next  = '0;
            dvd_next  = big_reg;
            accb_next = '0;
            accs_next = '0;
            cnt_next  = '0;
        end
        if (cmd.div_step)
        begin
            rem_next  = qbit ? trial[WIDTH-1:0] : shifted[WIDTH-1:0];
            dvd_next  = {dvd_reg[WIDTH-2:0], 1'b0};
            // horner form of q * c, quotient bits arrive msb first
            accb_next = {accb_reg[CF-2:0], 1'b0} + (qbit ? cnb_reg : '0);
            accs_next = {accs_reg[CF-2:0], 1'b0} + (qbit ? cns_reg : '0);
            cnt_next  = cnt_reg + CW'(1);
        end
        if (cmd.update)
        begin
            big_next   = small_reg;
            small_next = rem_reg;
            cob_next   = cnb_reg;
            cos_next   = cns_reg;
            cnb_next   = cob_reg - accb_reg;
            cns_next   = cos_reg - accs_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg   <= big_next;
        small_reg <= small_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        cob_reg   <= cob_next;
        cos_reg   <= cos_next;
        cnb_reg   <= cnb_next;
        cns_reg   <= cns_next;
        accb_reg  <= accb_next;
        accs_reg  <= accs_next;
        cnt_reg   <= cnt_next;
        swap_reg  <= swap_next;
        if (cmd.out_load)
        begin
            gcd_reg <= egcd_pkg::OPND_W'(big_reg);
            ca_reg  <= egcd_pkg::COEFF_W'(swap_reg ? cos_reg : cob_reg);
            cb_reg  <= egcd_pkg::COEFF_W'(swap_reg ? cob_reg : cos_reg);
        end
    end

    assign sts.small_zero = small_reg == '0;
    assign sts.div_last   = cnt_reg == CW'(WIDTH - 1);

    assign gcd_value = gcd_reg;
    assign coeff_a   = ca_reg;
    assign coeff_b   = cb_reg;

`ifndef ASSERT_OFF
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> small_reg != '0)
        else $error("division step with zero divisor");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < small_reg)
        else $error("partial remainder not below divisor");

    a_small_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> small_reg < $past(small_reg))
        else $error("euclid step did not reduce the smaller operand");
`endif

endmodule

>>> rtl/core/extended_gcd.sv
// ----------------------------------------------------------------------------
// extended_gcd
// Extended euclid: gcd of two unsigned operands with bezout coefficients.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries operand_a and operand_b; only
// the low WIDTH bits are used. Output channel out_valid/out_ready carries
// gcd_value and the signed coefficients coeff_a, coeff_b with
// operand_a*coeff_a + operand_b*coeff_b = gcd_value; coefficients are
// WIDTH+1 bit two's complement values.
// One request is worked on at a time; in_ready is high only when idle.
// The divider produces one quotient bit per cycle while the coefficient
// products are accumulated from the same bits. Up to about 1.44*WIDTH euclid
// iterations are run, none when the smaller operand is zero. The next request
// can be accepted at the earliest in the same cycle that the result appears.
// A result goes to an output register; the next request is accepted while
// it waits, and a stalled receiver only holds the block before it would
// overwrite that register. Reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
module extended_gcd #(
    parameter int unsigned WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [egcd_pkg::OPND_W-1:0]           operand_a,
    input  logic [egcd_pkg::OPND_W-1:0]           operand_b,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [egcd_pkg::OPND_W-1:0]           gcd_value,
    output logic signed [egcd_pkg::COEFF_W-1:0]   coeff_a,
    output logic signed [egcd_pkg::COEFF_W-1:0]   coeff_b
);

    egcd_pkg::egcd_cmd_t cmd;
    egcd_pkg::egcd_sts_t sts;

    egcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    egcd_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .gcd_value (gcd_value),
        .coeff_a   (coeff_a),
        .coeff_b   (coeff_b)
    );

endmodule

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the extended gcd block: each accepted request is
// run through a local bezout predictor and every result is compared, field
// by field, with the oldest prediction. Directed edge cases come first, then
// random operand mixes with random idling on both channels, then a streaming
// run with no idling.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned WIDTH      = 32;
    localparam int unsigned HALF_CYCLE = 10;
    localparam int unsigned DRAIN_CYC  = 100;
    // time limit for the whole run, allowing for the worst chains plus idling
    localparam longint unsigned RUN_LIMIT = 64'd60_000_000;

    typedef struct packed {
        logic [egcd_pkg::OPND_W-1:0]         gcd;
        logic signed [egcd_pkg::COEFF_W-1:0] ca;
        logic signed [egcd_pkg::COEFF_W-1:0] cb;
    } bezout_t;

    logic                                  clk       = 1'b0;
    logic                                  rst_n     = 1'b0;
    logic                                  in_valid  = 1'b0;
    logic                                  in_ready;
    logic [egcd_pkg::OPND_W-1:0]           operand_a = '0;
    logic [egcd_pkg::OPND_W-1:0]           operand_b = '0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic [egcd_pkg::OPND_W-1:0]           gcd_value;
    logic signed [egcd_pkg::COEFF_W-1:0]   coeff_a;
    logic signed [egcd_pkg::COEFF_W-1:0]   coeff_b;

    bezout_t     bezout_expect_q[$];
    int unsigned error_count  = 0;
    bit          stall_enable = 1'b0;
    int unsigned ready_hold   = 0;

    extended_gcd #(
        .WIDTH(WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .gcd_value (gcd_value),
        .coeff_a   (coeff_a),
        .coeff_b   (coeff_b)
    );

    always #(HALF_CYCLE) clk = ~clk;

    // coefficients live as two's complement in wrapping 64-bit words
    function automatic bezout_t predict_bezout(
        logic [egcd_pkg::OPND_W-1:0] a,
        logic [egcd_pkg::OPND_W-1:0] b
    );
        logic [63:0] in_mask;
        logic [63:0] coef_mask;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] old_hi;
        logic [63:0] old_lo;
        logic [63:0] new_hi;
        logic [63:0] new_lo;
        logic [63:0] nxt_hi;
        logic [63:0] nxt_lo;
        bit          exchanged;
        bezout_t     res;
        in_mask   = (64'd1 << WIDTH) - 64'd1;
        coef_mask = (64'd2 << WIDTH) - 64'd1;
        hi        = {32'd0, a} & in_mask;
        lo        = {32'd0, b} & in_mask;
        exchanged = 1'b0;
        if (hi < lo)
        begin
            {hi, lo}  = {lo, hi};
            exchanged = 1'b1;
        end
        old_hi = 64'd1;
        old_lo = 64'd0;
        new_hi = 64'd0;
        new_lo = 64'd1;
        while (lo != 64'd0)
        begin
            quo    = hi / lo;
            rem    = hi % lo;
            nxt_hi = old_hi - quo * new_hi;
            nxt_lo = old_lo - quo * new_lo;
            hi     = lo;
            lo     = rem;
            old_hi = new_hi;
            old_lo = new_lo;
            new_hi = nxt_hi;
            new_lo = nxt_lo;
        end
        old_hi  = old_hi & coef_mask;
        old_lo  = old_lo & coef_mask;
        res.gcd = hi[egcd_pkg::OPND_W-1:0] & in_mask[egcd_pkg::OPND_W-1:0];
        if (exchanged)
        begin
            res.ca = old_lo[egcd_pkg::COEFF_W-1:0];
            res.cb = old_hi[egcd_pkg::COEFF_W-1:0];
        end
        else
        begin
            res.ca = old_hi[egcd_pkg::COEFF_W-1:0];
            res.cb = old_lo[egcd_pkg::COEFF_W-1:0];
        end
        return res;
    endfunction

    // caller sits just after a posedge; drives at a falling edge, after a random idle gap when stalls are enabled
    task automatic send_request(
        logic [egcd_pkg::OPND_W-1:0] a,
        logic [egcd_pkg::OPND_W-1:0] b
    );
        int unsigned gap;
        gap = 0;
        @(negedge clk);
        if (stall_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        bezout_expect_q.push_back(predict_bezout(a, b));
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // receiver side: ready stalls in bursts of random length when stalls are enabled
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (stall_enable && $urandom_range(0, 5) == 0)
        begin
            ready_hold = $urandom_range(0, 17);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        bezout_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (bezout_expect_q.size() == 0)
            begin
                $display("%0t: result with no request pending: gcd %h ca %h cb %h",
                         $time, gcd_value, coeff_a, coeff_b);
                error_count++;
            end
            else
            begin
                exp_res = bezout_expect_q.pop_front();
                if (gcd_value !== exp_res.gcd)
                begin
                    $display("%0t: gcd_value expected %h actual %h",
                             $time, exp_res.gcd, gcd_value);
                    error_count++;
                end
                if (coeff_a !== exp_res.ca)
                begin
                    $display("%0t: coeff_a expected %h actual %h",
                             $time, exp_res.ca, coeff_a);
                    error_count++;
                end
                if (coeff_b !== exp_res.cb)
                begin
                    $display("%0t: coeff_b expected %h actual %h",
                             $time, exp_res.cb, coeff_b);
                    error_count++;
                end
            end
        end
    end

    task automatic test_zero_operands();
        send_request(32'd0, 32'd0);
        send_request(32'd0, 32'd5);
        send_request(32'd7, 32'd0);
        send_request(32'd0, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd0);
        release_input();
    endtask

    task automatic test_equal_operands();
        send_request(32'd1, 32'd1);
        send_request(32'd12345, 32'd12345);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        release_input();
    endtask

    task automatic test_extremes_and_swap();
        send_request(32'd1, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_request(32'h8000_0000, 32'h4000_0000);
        send_request(32'd240, 32'd46);
        send_request(32'd46, 32'd240);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        release_input();
    endtask

    // consecutive fibonacci numbers give the longest remainder chain
    task automatic test_longest_chains();
        send_request(32'd2971215073, 32'd1836311903);
        send_request(32'd1836311903, 32'd2971215073);
        send_request(32'd1134903170, 32'd1836311903);
        release_input();
    endtask

    task automatic test_random_mix(int unsigned count);
        logic [egcd_pkg::OPND_W-1:0] a;
        logic [egcd_pkg::OPND_W-1:0] b;
        logic [egcd_pkg::OPND_W-1:0] f0;
        logic [egcd_pkg::OPND_W-1:0] f1;
        logic [egcd_pkg::OPND_W-1:0] common;
        int unsigned                 k;
        int unsigned                 i;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    a = $urandom;
                    b = $urandom;
                end
                3:
                begin
                    a = $urandom_range(0, 300);
                    b = $urandom_range(0, 300);
                end
                4:
                begin
                    // shared factor so the gcd is large
                    common = $urandom_range(1, 65535);
                    a = common * $urandom_range(1, 65535);
                    b = common * $urandom_range(1, 65535);
                end
                5:
                begin
                    k  = $urandom_range(2, 46);
                    f0 = 32'd1;
                    f1 = 32'd1;
                    for (i = 2; i < k; i++)
                    begin
                        f1 = f0 + f1;
                        f0 = f1 - f0;
                    end
                    if ($urandom_range(0, 1))
                        {a, b} = {f1 + f0, f1};
                    else
                        {a, b} = {f1, f1 + f0};
                end
                6:
                begin
                    a = $urandom;
                    b = 32'd0;
                    if ($urandom_range(0, 1))
                        {a, b} = {b, a};
                end
                7:
                begin
                    a = $urandom;
                    b = a;
                end
                8:
                begin
                    a = 32'd1 << $urandom_range(0, 31);
                    b = $urandom;
                end
                default:
                begin
                    a = $urandom | 32'h8000_0000;
                    b = $urandom >> $urandom_range(0, 31);
                end
            endcase
            send_request(a, b);
        end
        release_input();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_operands();
        test_equal_operands();
        test_extremes_and_swap();
        test_longest_chains();

        stall_enable = 1'b1;
        test_random_mix(200);

        stall_enable = 1'b0;
        test_random_mix(80);

        while (bezout_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        if (error_count == 0 && bezout_expect_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("%0t: run limit reached", $time);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
